// ===== hw/rtl/vmh_pkg.sv =====
package vmh_pkg;

   // Defaults for the top-level parameters.
   localparam int BIN_COUNT_DEFAULT   = 65536;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Fixed field widths of the channels.
   localparam int SAMPLE_WIDTH    = 16;
   localparam int INDEX_WIDTH     = 16;
   localparam int VALUE_WIDTH     = 17;
   localparam int OUT_COUNT_WIDTH = 32;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Codes of the kind field of a request word.
   localparam logic [1:0] KIND_ACC   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      VT_U8  = 2'd0,
      VT_S8  = 2'd1,
      VT_U16 = 2'd2,
      VT_S16 = 2'd3
   } vt_type;

   typedef enum logic [1:0] {
      OP_ACC,
      OP_READ,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WAIT
   } bk_state_type;

   typedef struct packed {
      op_type                         op;
      logic [INDEX_WIDTH-1:0]         idx;
      logic signed [VALUE_WIDTH-1:0]  val;
      logic                           in_range;
   } q_entry_type;

   typedef struct packed {
      logic can_push;
      logic has_data;
   } q_status_type;

endpackage

// ===== hw/rtl/vmh_if.sv =====
interface vmh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] sample;
   logic [15:0] bin_index;

   modport source (output valid, kind, sample, bin_index, input ready);
   modport sink   (input valid, kind, sample, bin_index, output ready);
endinterface

interface vmh_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        bin_count;
   logic signed [16:0] min_value;
   logic signed [16:0] max_value;
   logic               any_seen;

   modport source (output valid, bin_count, min_value, max_value, any_seen, input ready);
   modport sink   (input valid, bin_count, min_value, max_value, any_seen, output ready);
endinterface

interface vmh_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/vmh_ram.sv =====
module vmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/vmh_queue.sv =====
module vmh_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  vmh_pkg::q_entry_type push_entry,
   input  logic                 pop,
   output vmh_pkg::q_entry_type pop_entry,
   output vmh_pkg::q_status_type status
);

   localparam int DEPTH = vmh_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   vmh_pkg::q_entry_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry       = entries_ff[rd_ptr_ff];
   assign status.can_push = (count_ff != CW'(DEPTH));
   assign status.has_data = (count_ff != '0);

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CW'(DEPTH)))
      else $error("Queue written while full.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("Queue read while empty.");
`endif

endmodule

// ===== hw/rtl/vmh_front.sv =====
module vmh_front #(
   parameter int BIN_COUNT = vmh_pkg::BIN_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   vmh_req_if.sink               req_if,
   vmh_csr_if.sink               csr_if,
   input  logic                  init_busy,
   input  vmh_pkg::q_status_type q_status,
   output logic                  push,
   output vmh_pkg::q_entry_type  push_entry
);

   vmh_pkg::vt_type voxel_type_ff;
   logic [vmh_pkg::INDEX_WIDTH-1:0]        idx;
   logic signed [vmh_pkg::VALUE_WIDTH-1:0] val;

   always_ff @(posedge clock) begin
      if (reset) begin
         voxel_type_ff <= vmh_pkg::VT_U8;
      end else if (csr_if.valid && csr_if.ready) begin
         voxel_type_ff <= vmh_pkg::vt_type'(csr_if.data);
      end
   end

   assign csr_if.ready = 1'b1;

   // Bin index and signed value of a sample under the current voxel type.
   always_comb begin
      unique case (voxel_type_ff)
         vmh_pkg::VT_U8: begin
            idx = {8'd0, req_if.sample[7:0]};
            val = {9'd0, req_if.sample[7:0]};
         end
         vmh_pkg::VT_S8: begin
            idx = {8'd0, ~req_if.sample[7], req_if.sample[6:0]};
            val = {{9{req_if.sample[7]}}, req_if.sample[7:0]};
         end
         vmh_pkg::VT_U16: begin
            idx = req_if.sample;
            val = {1'b0, req_if.sample};
         end
         vmh_pkg::VT_S16: begin
            idx = {~req_if.sample[15], req_if.sample[14:0]};
            val = {req_if.sample[15], req_if.sample};
         end
         default: begin
            idx = req_if.sample;
            val = {1'b0, req_if.sample};
         end
      endcase
   end

   always_comb begin
      push_entry.val = val;
      unique case (req_if.kind)
         vmh_pkg::KIND_ACC: begin
            push_entry.op  = vmh_pkg::OP_ACC;
            push_entry.idx = idx;
         end
         vmh_pkg::KIND_READ: begin
            push_entry.op  = vmh_pkg::OP_READ;
            push_entry.idx = req_if.bin_index;
         end
         vmh_pkg::KIND_CLEAR: begin
            push_entry.op  = vmh_pkg::OP_CLEAR;
            push_entry.idx = req_if.bin_index;
         end
         default: begin
            push_entry.op  = vmh_pkg::OP_NOP;
            push_entry.idx = req_if.bin_index;
         end
      endcase
      push_entry.in_range = ({1'b0, push_entry.idx} < 17'(BIN_COUNT));
   end

   assign req_if.ready = q_status.can_push && !init_busy;
   assign push         = req_if.valid && req_if.ready;

endmodule

// ===== hw/rtl/vmh_back.sv =====
module vmh_back #(
   parameter int BIN_COUNT   = vmh_pkg::BIN_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = vmh_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vmh_pkg::q_status_type q_status,
   input  vmh_pkg::q_entry_type  pop_entry,
   output logic                  pop,
   output logic                  init_busy,
   vmh_rsp_if.source             rsp_if
);

   localparam int AW = $clog2(BIN_COUNT);
   localparam int OW = vmh_pkg::OUT_COUNT_WIDTH;
   localparam int VW = vmh_pkg::VALUE_WIDTH;

   vmh_pkg::bk_state_type state_ff, state_in;
   logic [AW-1:0]          sweep_ff, sweep_in;
   logic                   clr_item_ff, clr_item_in;
   vmh_pkg::q_entry_type   cur_ff, cur_in;
   logic signed [VW-1:0]   min_ff, min_in;
   logic signed [VW-1:0]   max_ff, max_in;
   logic                   seen_ff, seen_in;

   logic                   out_valid_ff, out_valid_in;
   logic [OW-1:0]          out_count_ff, out_count_in;
   logic signed [VW-1:0]   out_min_ff, out_min_in;
   logic signed [VW-1:0]   out_max_ff, out_max_in;
   logic                   out_seen_ff, out_seen_in;

   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] inc_count;
   logic [OW-1:0]          rd_out, inc_out;

   vmh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BIN_COUNT)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pop_entry.idx[AW-1:0]),
      .rd_data (rd_data)
   );

   // Saturating increment of the bin just read.
   assign inc_count = (rd_data == '1) ? rd_data : rd_data + COUNT_WIDTH'(1);

   // Counts wider than the result field saturate on the way out.
   generate
      if (COUNT_WIDTH > OW) begin : g_wide
         assign rd_out  = (|rd_data[COUNT_WIDTH-1:OW])   ? '1 : rd_data[OW-1:0];
         assign inc_out = (|inc_count[COUNT_WIDTH-1:OW]) ? '1 : inc_count[OW-1:0];
      end else begin : g_narrow
         assign rd_out  = OW'(rd_data);
         assign inc_out = OW'(inc_count);
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      clr_item_in  = clr_item_ff;
      cur_in       = cur_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      seen_in      = seen_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_count_in = out_count_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      out_seen_in  = out_seen_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur_ff.idx[AW-1:0];
      wr_data      = inc_count;

      unique case (state_ff)
         vmh_pkg::BK_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == AW'(BIN_COUNT - 1)) begin
               sweep_in = '0;
               state_in = vmh_pkg::BK_IDLE;
               if (clr_item_ff) begin
                  clr_item_in  = 1'b0;
                  out_valid_in = 1'b1;
                  out_count_in = '0;
                  out_min_in   = '0;
                  out_max_in   = '0;
                  out_seen_in  = 1'b0;
               end
            end
         end

         vmh_pkg::BK_IDLE: begin
            if (q_status.has_data && (!out_valid_ff || rsp_if.ready)) begin
               pop    = 1'b1;
               cur_in = pop_entry;
               case (pop_entry.op)
                  vmh_pkg::OP_ACC: begin
                     if (!seen_ff) begin
                        min_in  = pop_entry.val;
                        max_in  = pop_entry.val;
                        seen_in = 1'b1;
                     end else begin
                        if (pop_entry.val < min_ff) begin
                           min_in = pop_entry.val;
                        end
                        if (pop_entry.val > max_ff) begin
                           max_in = pop_entry.val;
                        end
                     end
                     if (pop_entry.in_range) begin
                        rd_en    = 1'b1;
                        state_in = vmh_pkg::BK_WAIT;
                     end else begin
                        out_valid_in = 1'b1;
                        out_count_in = '0;
                        out_min_in   = min_in;
                        out_max_in   = max_in;
                        out_seen_in  = 1'b1;
                     end
                  end
                  vmh_pkg::OP_READ: begin
                     if (pop_entry.in_range) begin
                        rd_en    = 1'b1;
                        state_in = vmh_pkg::BK_WAIT;
                     end else begin
                        out_valid_in = 1'b1;
                        out_count_in = '0;
                        out_min_in   = min_ff;
                        out_max_in   = max_ff;
                        out_seen_in  = seen_ff;
                     end
                  end
                  vmh_pkg::OP_CLEAR: begin
                     min_in      = '0;
                     max_in      = '0;
                     seen_in     = 1'b0;
                     clr_item_in = 1'b1;
                     state_in    = vmh_pkg::BK_CLEAR;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     out_count_in = '0;
                     out_min_in   = min_ff;
                     out_max_in   = max_ff;
                     out_seen_in  = seen_ff;
                  end
               endcase
            end
         end

         vmh_pkg::BK_WAIT: begin
            state_in     = vmh_pkg::BK_IDLE;
            out_valid_in = 1'b1;
            out_min_in   = min_ff;
            out_max_in   = max_ff;
            out_seen_in  = seen_ff;
            if (cur_ff.op == vmh_pkg::OP_ACC) begin
               wr_en        = 1'b1;
               out_count_in = inc_out;
            end else begin
               out_count_in = rd_out;
            end
         end

         default: begin
            state_in = vmh_pkg::BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vmh_pkg::BK_CLEAR;
         sweep_ff     <= '0;
         clr_item_ff  <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_item_ff  <= clr_item_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      out_count_ff <= out_count_in;
      out_min_ff   <= out_min_in;
      out_max_ff   <= out_max_in;
      out_seen_ff  <= out_seen_in;
   end

   assign init_busy        = (state_ff == vmh_pkg::BK_CLEAR) && !clr_item_ff;
   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.bin_count = out_count_ff;
   assign rsp_if.min_value = out_min_ff;
   assign rsp_if.max_value = out_max_ff;
   assign rsp_if.any_seen  = out_seen_ff;

`ifndef SYNTHESIS
   a_wait_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vmh_pkg::BK_WAIT) |-> ($past(state_ff) == vmh_pkg::BK_IDLE))
      else $error("Bin read result used without a preceding read.");
   a_unseen_is_zero: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> ((min_ff == '0) && (max_ff == '0)))
      else $error("Min or max tracking not cleared while nothing is seen.");
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (min_ff <= max_ff))
      else $error("Running minimum above running maximum.");
   a_no_result_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vmh_pkg::BK_CLEAR) |-> !out_valid_ff)
      else $error("Result pending during a clearing sweep.");
`endif

endmodule

// ===== hw/rtl/voxel_minmax_histogram_top.sv =====
// An accumulate or read word in range has its bin read as it leaves the queue and its
// result registered in the WAIT state; a clear word gives its result after its sweep.
// The back part takes no new word while an accumulate or read word is in the WAIT
// state or a clear sweeps; other words go one per cycle while each result is taken.
// Reset (synchronous, active high) starts a clearing pass over the bin RAM, during which
// req_if.ready is low; configuration writes are taken throughout.
module voxel_minmax_histogram_top #(
   parameter int BIN_COUNT   = vmh_pkg::BIN_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = vmh_pkg::COUNT_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   vmh_req_if.sink   req_if,
   vmh_rsp_if.source rsp_if,
   vmh_csr_if.sink   csr_if
);

   // The front part holds the voxel type register, works out the bin index and the
   // signed value of each sample, and classifies every request word into one
   // operation. Classified words go into a short queue, so that the front part keeps
   // accepting while the back part is busy with the bin RAM or a result is waiting.
   vmh_pkg::q_status_type q_status;
   vmh_pkg::q_entry_type  push_entry;
   vmh_pkg::q_entry_type  pop_entry;
   logic                  push;
   logic                  pop;
   logic                  init_busy;

   vmh_front #(
      .BIN_COUNT (BIN_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .init_busy  (init_busy),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   vmh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // The back part owns the bin RAM and the min/max tracking. It reads a bin and writes the
   // saturated count back in the next cycle, so a following word that hits the same bin
   // always sees the updated count. A clear word sweeps the RAM one bin per cycle before
   // its result is given. Results sit in an output register, and the back part takes the
   // next word from the queue in the cycle that the waiting result is taken.
   vmh_back #(
      .BIN_COUNT   (BIN_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop),
      .init_busy (init_busy),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== tb/voxel_minmax_histogram_top_test.sv =====
`timescale 1ns / 100ps

module voxel_minmax_histogram_top_test;

   // Geometry of the block as built with its default parameters.
   localparam int              BINS          = vmh_pkg::BIN_COUNT_DEFAULT;
   localparam longint unsigned TALLY_MAX     = (64'd1 << vmh_pkg::COUNT_WIDTH_DEFAULT) - 1;
   // The fourth code of the kind field is left unused by the block.
   localparam logic [1:0]      KIND_UNUSED   = 2'd3;
   // Length of the long receiver hold-off that fills the block up.
   localparam int              HOLD_CYCLES   = 200;
   // Quiet cycles after the last result before the register is touched.
   localparam int              SETTLE_CYCLES = 8;
   // Watchdog: room for the reset clearing pass, at most five clears of the whole
   // bin RAM, and all the items.
   localparam int              LIMIT_CYCLES  = 2_000_000;
   // Mismatches beyond this many are still counted but no longer printed.
   localparam int              PRINT_CAP     = 40;

   // One result word as the histogram is expected to return it.
   typedef struct packed {
      logic [31:0]        count;
      logic signed [16:0] lo;
      logic signed [16:0] hi;
      logic               seen;
   } hist_word_type;

   logic clock;
   logic reset;

   vmh_req_if req_if ();
   vmh_rsp_if rsp_if ();
   vmh_csr_if csr_if ();

   voxel_minmax_histogram_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Our own copy of the histogram state: the voxel type in force, a sparse
   // store of the bins that have been hit, and the running extremes.
   vmh_pkg::vt_type voxel_mode = vmh_pkg::VT_U8;
   longint unsigned bin_tally [int];
   int              run_lo     = 0;
   int              run_hi     = 0;
   bit              any_sample = 1'b0;

   // Result words still owed by the block, oldest first.
   hist_word_type   pending_words [$];
   // Bins touched lately, so that about half the reads can aim at a bin just hit.
   bit [15:0]       recent_bins [$];
   bit [15:0]       hot_base;

   int              err_count      = 0;
   int              clears_left    = 3;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   // Each toggle asks the receiver for one long hold-off.
   logic            hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the result word of one accepted request word and moves our
   // copy of the state on, exactly as the block is meant to.
   function automatic hist_word_type predict_histogram(input logic [1:0]  kind,
                                                       input logic [15:0] sample,
                                                       input logic [15:0] bin_index);
      hist_word_type   w;
      longint unsigned tally;
      int              idx;
      int              val;
      tally = 0;
      case (kind)
         vmh_pkg::KIND_ACC: begin
            // The bin index is the value less the lowest value of the type,
            // which for the signed types is the raw bits with the top one flipped.
            case (voxel_mode)
               vmh_pkg::VT_U8: begin
                  idx = sample[7:0];
                  val = idx;
               end
               vmh_pkg::VT_S8: begin
                  idx = sample[7:0] ^ 8'h80;
                  val = idx - 128;
               end
               vmh_pkg::VT_U16: begin
                  idx = sample;
                  val = idx;
               end
               default: begin
                  idx = sample ^ 16'h8000;
                  val = idx - 32768;
               end
            endcase
            // The first sample after a clear or reset sets both extremes.
            if (!any_sample) begin
               run_lo     = val;
               run_hi     = val;
               any_sample = 1'b1;
            end else begin
               if (val < run_lo) run_lo = val;
               if (val > run_hi) run_hi = val;
            end
            if (idx < BINS) begin
               if (!bin_tally.exists(idx)) bin_tally[idx] = 0;
               if (bin_tally[idx] < TALLY_MAX) bin_tally[idx]++;
               tally = bin_tally[idx];
               recent_bins.push_back(idx[15:0]);
               if (recent_bins.size() > 32) void'(recent_bins.pop_front());
            end
         end
         vmh_pkg::KIND_READ: begin
            if (bin_index < BINS && bin_tally.exists(int'(bin_index)))
               tally = bin_tally[int'(bin_index)];
         end
         vmh_pkg::KIND_CLEAR: begin
            bin_tally.delete();
            run_lo     = 0;
            run_hi     = 0;
            any_sample = 1'b0;
         end
         default: ;
      endcase
      // Counts wider than the output port stick at the all-ones value.
      w.count = (tally > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : tally[31:0];
      w.lo    = run_lo[16:0];
      w.hi    = run_hi[16:0];
      w.seen  = any_sample;
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      if (err_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
      err_count++;
   endtask

   // Offers one request word, after a random number of idle cycles, and records
   // the expected result once the word has been taken. The valid line is left
   // high afterwards; the next call or a drain decides what happens to it.
   task automatic send_word(input logic [1:0]  kind,
                            input logic [15:0] sample,
                            input logic [15:0] bin_index);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.kind      <= kind;
      req_if.sample    <= sample;
      req_if.bin_index <= bin_index;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      pending_words.push_back(predict_histogram(kind, sample, bin_index));
   endtask

   // Stops offering words and waits until every owed result has come back,
   // then lets the block settle.
   task automatic await_drain();
      req_if.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The voxel type is only changed while the block is idle.
   task automatic write_voxel_type(input vmh_pkg::vt_type t);
      await_drain();
      csr_if.valid <= 1'b1;
      csr_if.data  <= t;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      csr_if.valid <= 1'b0;
      voxel_mode = t;
   endtask

   // Random words: mostly samples, many of them clustered round one value so
   // that bins build up, reads aimed half the time at bins just hit, some
   // words of the unused kind and, rarely, a clear.
   task automatic random_burst(input int n);
      int          r;
      logic [1:0]  kind;
      logic [15:0] sample;
      logic [15:0] bin_index;
      hot_base = 16'($urandom);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if ($urandom_range(1) == 0) sample = hot_base ^ 16'($urandom_range(15));
         else sample = 16'($urandom);
         bin_index = 16'($urandom);
         if (recent_bins.size() != 0 && $urandom_range(1) == 0)
            bin_index = recent_bins[$urandom_range(recent_bins.size() - 1)];
         if (r == 0 && clears_left > 0) begin
            kind = vmh_pkg::KIND_CLEAR;
            clears_left--;
         end else if (r < 60) begin
            kind = vmh_pkg::KIND_ACC;
         end else if (r < 90) begin
            kind = vmh_pkg::KIND_READ;
         end else begin
            kind = KIND_UNUSED;
         end
         send_word(kind, sample, bin_index);
      end
   endtask

   // Byte types: both ends of each range, upper sample bits that must be
   // ignored, the unused kind, a change of type without a clear, and the
   // first sample after a clear.
   task automatic test_byte_types();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_voxel_type(vmh_pkg::VT_U8);
      send_word(vmh_pkg::KIND_ACC,   16'h0000, 16'h0000);
      send_word(vmh_pkg::KIND_ACC,   16'hABFF, 16'h0000);
      send_word(vmh_pkg::KIND_ACC,   16'h5400, 16'hFFFF);
      send_word(vmh_pkg::KIND_READ,  16'h0000, 16'h00FF);
      send_word(vmh_pkg::KIND_READ,  16'hFFFF, 16'hFFFF);
      send_word(KIND_UNUSED,         16'hFFFF, 16'hFFFF);
      // The bins and extremes carry over into the signed byte type.
      write_voxel_type(vmh_pkg::VT_S8);
      send_word(vmh_pkg::KIND_ACC,   16'h0080, 16'h0000);
      send_word(vmh_pkg::KIND_ACC,   16'hFF7F, 16'h0000);
      send_word(vmh_pkg::KIND_CLEAR, 16'hFFFF, 16'hFFFF);
      send_word(vmh_pkg::KIND_READ,  16'h0000, 16'h0000);
      send_word(KIND_UNUSED,         16'h0000, 16'h0000);
      send_word(vmh_pkg::KIND_ACC,   16'h00FF, 16'h0000);
   endtask

   // 16-bit types: the full unsigned range on top of a negative minimum left
   // by the byte test, then the signed extremes and a clear.
   task automatic test_word_types();
      write_voxel_type(vmh_pkg::VT_U16);
      send_word(vmh_pkg::KIND_ACC,   16'hFFFF, 16'h0000);
      send_word(vmh_pkg::KIND_ACC,   16'h0000, 16'h0000);
      send_word(vmh_pkg::KIND_READ,  16'h0000, 16'hFFFF);
      write_voxel_type(vmh_pkg::VT_S16);
      send_word(vmh_pkg::KIND_ACC,   16'h8000, 16'h0000);
      send_word(vmh_pkg::KIND_ACC,   16'h7FFF, 16'h0000);
      send_word(vmh_pkg::KIND_READ,  16'h0000, 16'h0000);
      send_word(vmh_pkg::KIND_CLEAR, 16'h0000, 16'h0000);
      send_word(vmh_pkg::KIND_ACC,   16'h7FFF, 16'h0000);
      send_word(vmh_pkg::KIND_READ,  16'h0000, 16'hFFFF);
   endtask

   // One stretch of random traffic at the given idling rates, walking through
   // all four voxel types from a random starting point.
   task automatic test_random_stream(input int send_pct, input int recv_pct, input int n);
      int start;
      start          = $urandom_range(3);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int k = 0; k < 4; k++) begin
         write_voxel_type(vmh_pkg::vt_type'(2'((start + k) % 4)));
         random_burst(n / 4);
      end
   endtask

   // The receiver holds off for a long stretch while words keep coming, so the
   // block fills and stalls its input; then the sender pauses until every
   // result is back before carrying on.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_voxel_type(vmh_pkg::VT_S16);
      hold_req <= ~hold_req;
      random_burst(24);
      await_drain();
      random_burst(12);
      await_drain();
   endtask

   // Receiver: checks every result word taken against the oldest expectation
   // and chooses the ready line for the next cycle.
   initial begin
      logic          hold_seen;
      int            hold_left;
      hist_word_type want;
      hold_seen = 1'b0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_words.size() == 0) begin
               report_mismatch($sformatf("result word with none expected, count %0d",
                                         rsp_if.bin_count));
            end else begin
               want = pending_words.pop_front();
               if (rsp_if.bin_count !== want.count)
                  report_mismatch($sformatf("bin_count %0d, expected %0d",
                                            rsp_if.bin_count, want.count));
               if (rsp_if.min_value !== want.lo)
                  report_mismatch($sformatf("min_value %0d, expected %0d",
                                            rsp_if.min_value, want.lo));
               if (rsp_if.max_value !== want.hi)
                  report_mismatch($sformatf("max_value %0d, expected %0d",
                                            rsp_if.max_value, want.hi));
               if (rsp_if.any_seen !== want.seen)
                  report_mismatch($sformatf("any_seen %0b, expected %0b",
                                            rsp_if.any_seen, want.seen));
            end
         end
         if (hold_req !== hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.kind      <= vmh_pkg::KIND_ACC;
      req_if.sample    <= 16'h0000;
      req_if.bin_index <= 16'h0000;
      csr_if.valid     <= 1'b0;
      csr_if.data      <= vmh_pkg::VT_U8;
      hold_req         <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The block runs a clearing pass after reset with its input held off;
      // the first word simply waits for it.
      test_byte_types();
      test_word_types();
      // The sender idles less than the receiver, then the other way round,
      // then neither idles at all.
      test_random_stream(30, 67, 120);
      test_random_stream(67, 30, 120);
      test_random_stream(0, 0, 120);
      test_backpressure();
      await_drain();

      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
